>>> rtl/cubic_congestion_window_unit_assert.svh
// Assertion macros for the congestion window unit.
`ifndef CUBIC_CONGESTION_WINDOW_UNIT_ASSERT_SVH
`define CUBIC_CONGESTION_WINDOW_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define CCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define CCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ccw_pkg.sv
// Shared constants for the congestion window unit.
package ccw_pkg;

    localparam int OP_W       = 64;
    localparam int PROD_W     = 68;
    localparam int CNT_W      = 6;
    localparam int CBRT_STEPS = 22;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OP_W - 1);

    localparam logic [63:0] SEG_BYTES    = 64'd1460;
    localparam logic [63:0] CUBE_SCALE   = 64'd1836805;
    localparam logic [63:0] CURVE_SCALE  = 64'd598600;
    localparam logic [63:0] ELAP_DIVISOR = 64'd1000;
    localparam logic [39:0] MASK40       = 40'hFF_FFFF_FFFF;

    localparam logic MODE_LOSS = 1'b1;

    localparam logic [1:0] REG_BETA     = 2'd0;
    localparam logic [1:0] REG_BETA_MAX = 2'd1;
    localparam logic [1:0] REG_ALPHA    = 2'd2;
    localparam logic [1:0] REG_SPARE    = 2'd3;

endpackage

>>> rtl/ccw_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module ccw_mul
    import ccw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OP_W-1:0]   a,
    input  logic [OP_W-1:0]   b,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] a_reg;
    logic [OP_W-1:0]   b_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PROD_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[PROD_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[OP_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> rtl/ccw_div.sv
// Restoring divider, one quotient bit per cycle.
module ccw_div
    import ccw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] num,
    input  logic [OP_W-1:0] den,
    output logic            done,
    output logic [OP_W-1:0] quot
);

    logic [OP_W-1:0]  q_reg;
    logic [OP_W-1:0]  rem_reg;
    logic [OP_W-1:0]  den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [OP_W:0]    trial;
    logic [OP_W:0]    diff;
    logic             ge;

    assign trial = {rem_reg, q_reg[OP_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[OP_W-1:0] : trial[OP_W-1:0];
            q_reg   <= {q_reg[OP_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/cubic_congestion_window_unit.sv
// CUBIC congestion window unit: sequencer, cube root and serial arithmetic.
// Loss request: two passes of the serial multiplier.
// Ack request: up to five serial multiplier passes, up to two serial divider
//   passes and, when an epoch starts, a digit-serial cube root. One request in
//   flight; the next is taken once its result has moved to the output register.
// Reset (async, active low) clears the curve state and restores register defaults.
module cubic_congestion_window_unit
    import ccw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cwnd[31:0], ack_len[63:32], min_delay_ms[83:64], event_time_ms[131:84]
    input  logic [135:0] s_tdata,
    // mode[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_cwnd[39:0]
    output logic [39:0]  m_tdata
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_LOSS_LM  = 14'b00000000000010,
        ST_LOSS_B   = 14'b00000000000100,
        ST_EPOCH    = 14'b00000000001000,
        ST_ORG_MUL  = 14'b00000000010000,
        ST_CBRT     = 14'b00000000100000,
        ST_ELAP_GO  = 14'b00000001000000,
        ST_ELAP_DIV = 14'b00000010000000,
        ST_CUBE1    = 14'b00000100000000,
        ST_CUBE2    = 14'b00001000000000,
        ST_CUBE3    = 14'b00010000000000,
        ST_EST_MUL  = 14'b00100000000000,
        ST_EST_DIV  = 14'b01000000000000,
        ST_FINISH   = 14'b10000000000000
    } state_t;

    state_t state_reg;

    logic [16:0] beta_reg;
    logic [16:0] beta_max_reg;
    logic [23:0] alpha_reg;

    logic [47:0] epoch_reg;
    logic [39:0] lmw_reg;
    logic [39:0] est_reg;
    logic [31:0] ot_reg;
    logic [39:0] ow_reg;

    logic [31:0] cwnd_reg;
    logic [31:0] acked_reg;
    logic [19:0] delay_reg;
    logic [47:0] now_reg;

    logic [63:0] elapsed_reg;
    logic [63:0] d_reg;
    logic [63:0] ret_reg;
    logic [63:0] inc_reg;
    logic [39:0] res_reg;
    logic        out_pend_reg;

    logic [65:0] x_reg;
    logic [49:0] rem_reg;
    logic [21:0] y_reg;
    logic [43:0] y2_reg;
    logic [4:0]  k_reg;

    logic        mul_start_reg;
    logic [63:0] mul_a_reg;
    logic [63:0] mul_b_reg;
    logic        div_start_reg;
    logic [63:0] div_n_reg;
    logic [63:0] div_d_reg;

    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    logic              mul_done;
    logic [PROD_W-1:0] mul_prod;
    logic              div_done;
    logic [OP_W-1:0]   div_quot;

    // cube root digit step
    logic [49:0] cb_trial;
    logic [49:0] cb_b;
    logic        cb_ge;
    logic [21:0] y_next;
    logic [43:0] y2_next;
    logic [49:0] rem_next;

    logic [63:0] elap_t;
    logic [63:0] dist_diff;
    logic [63:0] dist_abs;
    logic [63:0] delta;
    logic [63:0] curve;
    logic [63:0] cap;
    logic [63:0] capped;
    logic [63:0] seg_p;
    logic [64:0] est_sum;
    logic [39:0] est_sat;
    logic [32:0] cwnd_seg;

    ccw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ccw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_n_reg),
        .den   (div_d_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        cb_trial = {rem_reg[46:0], x_reg[65:63]};
        cb_b     = 50'({y2_reg, 3'b000}) + 50'({y2_reg, 2'b00})
                 + 50'({y_reg, 2'b00}) + 50'({y_reg, 1'b0}) + 50'd1;
        cb_ge    = (cb_trial >= cb_b);
        rem_next = cb_ge ? (cb_trial - cb_b) : cb_trial;
        y_next   = {y_reg[20:0], cb_ge};
        y2_next  = cb_ge ? ({y2_reg[41:0], 2'b00} + 44'({y_reg, 2'b00}) + 44'd1)
                         : {y2_reg[41:0], 2'b00};

        elap_t    = 64'(now_reg) + 64'(delay_reg) - 64'(epoch_reg);
        dist_diff = 64'(ot_reg) - div_quot;
        dist_abs  = dist_diff[63] ? (64'd0 - dist_diff) : dist_diff;

        delta  = 64'(mul_prod[63:40]);
        curve  = (elapsed_reg > 64'(ot_reg)) ? (64'(ow_reg) + delta)
                                             : (64'(ow_reg) - delta);
        cap    = 64'(33'(cwnd_reg) + 33'(acked_reg[31:1]));
        capped = (curve > cap) ? cap : curve;
        seg_p  = 64'(acked_reg) * SEG_BYTES;

        est_sum = 65'(est_reg) + 65'(inc_reg);
        est_sat = (est_sum > 65'(MASK40)) ? MASK40 : est_sum[39:0];

        cwnd_seg = 33'(cwnd_reg) + 33'(SEG_BYTES[10:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            beta_reg      <= 17'd45875;
            beta_max_reg  <= 17'd55706;
            alpha_reg     <= 24'd34696;
            epoch_reg     <= '0;
            lmw_reg       <= '0;
            est_reg       <= '0;
            ot_reg        <= '0;
            ow_reg        <= '0;
            cwnd_reg      <= '0;
            acked_reg     <= '0;
            delay_reg     <= '0;
            now_reg       <= '0;
            elapsed_reg   <= '0;
            d_reg         <= '0;
            ret_reg       <= '0;
            inc_reg       <= '0;
            res_reg       <= '0;
            out_pend_reg  <= 1'b0;
            x_reg         <= '0;
            rem_reg       <= '0;
            y_reg         <= '0;
            y2_reg        <= '0;
            k_reg         <= '0;
            mul_start_reg <= 1'b0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            div_start_reg <= 1'b0;
            div_n_reg     <= '0;
            div_d_reg     <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BETA:     beta_reg     <= cfg_data[16:0];
                    REG_BETA_MAX: beta_max_reg <= cfg_data[16:0];
                    REG_ALPHA:    alpha_reg    <= cfg_data;
                    default:      ;
                endcase
            end

            // result register hand-off
            if (out_pend_reg && (!m_valid_reg || m_tready))
            begin
                m_data_reg   <= res_reg;
                m_valid_reg  <= 1'b1;
                out_pend_reg <= 1'b0;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        cwnd_reg  <= s_tdata[31:0];
                        acked_reg <= s_tdata[63:32];
                        delay_reg <= s_tdata[83:64];
                        now_reg   <= s_tdata[131:84];
                        if (s_tuser[0] == MODE_LOSS)
                        begin
                            mul_a_reg     <= 64'(s_tdata[31:0]);
                            mul_b_reg     <= 64'(beta_max_reg);
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_LOSS_LM;
                        end
                        else
                        begin
                            state_reg <= ST_EPOCH;
                        end
                    end
                end

                ST_LOSS_LM:
                begin
                    if (mul_done)
                    begin
                        if (40'(cwnd_seg) < lmw_reg)
                        begin
                            lmw_reg <= mul_prod[55:16];
                        end
                        else
                        begin
                            lmw_reg <= 40'(cwnd_reg);
                        end
                        epoch_reg     <= '0;
                        mul_a_reg     <= 64'(cwnd_reg);
                        mul_b_reg     <= 64'(beta_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_LOSS_B;
                    end
                end

                ST_LOSS_B:
                begin
                    if (mul_done)
                    begin
                        res_reg      <= mul_prod[55:16];
                        out_pend_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                ST_EPOCH:
                begin
                    if (epoch_reg == '0)
                    begin
                        epoch_reg <= now_reg;
                        est_reg   <= 40'(cwnd_reg);
                        if (lmw_reg <= 40'(cwnd_reg))
                        begin
                            ot_reg    <= '0;
                            ow_reg    <= 40'(cwnd_reg);
                            state_reg <= ST_ELAP_GO;
                        end
                        else
                        begin
                            ow_reg        <= lmw_reg;
                            mul_a_reg     <= 64'(lmw_reg - 40'(cwnd_reg));
                            mul_b_reg     <= CUBE_SCALE;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_ORG_MUL;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_ELAP_GO;
                    end
                end

                ST_ORG_MUL:
                begin
                    if (mul_done)
                    begin
                        x_reg     <= {2'b00, mul_prod[63:0]};
                        rem_reg   <= '0;
                        y_reg     <= '0;
                        y2_reg    <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_CBRT;
                    end
                end

                ST_CBRT:
                begin
                    x_reg   <= {x_reg[62:0], 3'b000};
                    rem_reg <= rem_next;
                    y_reg   <= y_next;
                    y2_reg  <= y2_next;
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == 5'(CBRT_STEPS - 1))
                    begin
                        ot_reg    <= 32'(y_next);
                        state_reg <= ST_ELAP_GO;
                    end
                end

                ST_ELAP_GO:
                begin
                    div_n_reg     <= {elap_t[53:0], 10'b0};
                    div_d_reg     <= ELAP_DIVISOR;
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_ELAP_DIV;
                end

                ST_ELAP_DIV:
                begin
                    if (div_done)
                    begin
                        elapsed_reg   <= div_quot;
                        d_reg         <= dist_abs;
                        mul_a_reg     <= dist_abs;
                        mul_b_reg     <= dist_abs;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_CUBE1;
                    end
                end

                ST_CUBE1:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= mul_prod[63:0];
                        mul_b_reg     <= d_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_CUBE2;
                    end
                end

                ST_CUBE2:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= mul_prod[63:0];
                        mul_b_reg     <= CURVE_SCALE;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_CUBE3;
                    end
                end

                ST_CUBE3:
                begin
                    if (mul_done)
                    begin
                        ret_reg       <= capped;
                        mul_a_reg     <= seg_p;
                        mul_b_reg     <= 64'(alpha_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_EST_MUL;
                    end
                end

                ST_EST_MUL:
                begin
                    if (mul_done)
                    begin
                        if (est_reg != '0)
                        begin
                            div_n_reg     <= 64'(mul_prod[PROD_W-1:16]);
                            div_d_reg     <= 64'(est_reg);
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_EST_DIV;
                        end
                        else
                        begin
                            inc_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                    end
                end

                ST_EST_DIV:
                begin
                    if (div_done)
                    begin
                        inc_reg   <= div_quot;
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    est_reg      <= est_sat;
                    res_reg      <= (ret_reg < 64'(est_sat)) ? est_sat : ret_reg[39:0];
                    out_pend_reg <= 1'b1;
                    state_reg    <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_pend_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`include "cubic_congestion_window_unit_assert.svh"

    `CCW_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_reg), "state not one-hot")
    `CCW_ASSERT_NEXT(a_loss_path, s_tvalid && s_tready && (s_tuser[0] == MODE_LOSS),
        state_reg == ST_LOSS_LM, "loss request did not enter loss path")
    `CCW_ASSERT_NEXT(a_est_grows, state_reg == ST_FINISH, est_reg >= $past(est_reg),
        "estimated window shrank on ack")
    `CCW_ASSERT_NEXT(a_result_out, out_pend_reg && (!m_valid_reg || m_tready),
        m_valid_reg && !out_pend_reg, "pending result not moved to output")

endmodule

>>> tb/sv/tb_cubic_congestion_window_unit.sv
// Testbench for the CUBIC congestion window unit: scoreboard, stimulus and checks.
module tb_cubic_congestion_window_unit
    import ccw_pkg::*;
();

    class cwnd_scoreboard;
        logic [16:0] beta;
        logic [16:0] beta_max;
        logic [23:0] alpha;
        logic [63:0] epoch_start;
        logic [63:0] last_max;
        logic [63:0] est_window;
        logic [63:0] origin_time;
        logic [63:0] origin_window;
        logic [39:0] pending_cwnd[$];
        int errors;

        function void clear();
            beta = 17'd45875;
            beta_max = 17'd55706;
            alpha = 24'd34696;
            epoch_start = '0;
            last_max = '0;
            est_window = '0;
            origin_time = '0;
            origin_window = '0;
            errors = 0;
            pending_cwnd.delete();
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            if (idx == REG_BETA)
                beta = val[16:0];
            else if (idx == REG_BETA_MAX)
                beta_max = val[16:0];
            else if (idx == REG_ALPHA)
                alpha = val;
        endfunction

        function logic [63:0] icbrt(logic [63:0] x);
            logic [63:0] y;
            logic [63:0] b;
            y = '0;
            for (int s = 63; s >= 0; s -= 3)
            begin
                y = y << 1;
                b = 64'd3 * y * (y + 64'd1) + 64'd1;
                if ((x >> s) >= b)
                begin
                    x = x - (b << s);
                    y = y + 64'd1;
                end
            end
            return y;
        endfunction

        function void note_request(logic is_loss, logic [31:0] cwnd_in, logic [31:0] acked,
                                   logic [19:0] delay, logic [47:0] now);
            logic [63:0] cw;
            logic [63:0] ret;
            logic [63:0] elapsed;
            logic [63:0] d;
            logic [63:0] delta;
            logic [63:0] cap;
            logic [63:0] p;
            logic [63:0] num;
            logic [63:0] inc;
            cw = {32'd0, cwnd_in};
            if (is_loss == MODE_LOSS)
            begin
                if (cw + SEG_BYTES < last_max)
                    last_max = ((64'(beta_max) * cw) >> 16) & 64'(MASK40);
                else
                    last_max = cw;
                epoch_start = '0;
                pending_cwnd.push_back(40'((cw * 64'(beta)) >> 16));
                return;
            end
            if (epoch_start == 0)
            begin
                epoch_start = 64'(now);
                est_window = cw;
                if (last_max <= cw)
                begin
                    origin_time = '0;
                    origin_window = cw;
                end
                else
                begin
                    origin_time = icbrt(CUBE_SCALE * (last_max - cw)) & 64'hFFFF_FFFF;
                    origin_window = last_max;
                end
            end
            elapsed = ((64'(now) + 64'(delay) - epoch_start) << 10) / ELAP_DIVISOR;
            d = origin_time - elapsed;
            if (d[63])
                d = 64'd0 - d;
            delta = (64'd410 * d * d * d * SEG_BYTES) >> 40;
            if (elapsed > origin_time)
                ret = origin_window + delta;
            else
                ret = origin_window - delta;
            cap = cw + 64'(acked >> 1);
            if (ret > cap)
                ret = cap;
            p = 64'(acked) * SEG_BYTES;
            num = p * 64'(alpha >> 16) + ((p * 64'(alpha[15:0])) >> 16);
            inc = (est_window != 0) ? num / est_window : 64'd0;
            est_window = est_window + inc;
            if (est_window > 64'(MASK40))
                est_window = 64'(MASK40);
            if (ret < est_window)
                ret = est_window;
            pending_cwnd.push_back(ret[39:0]);
        endfunction

        function void check_result(logic [39:0] got);
            logic [39:0] want;
            if (pending_cwnd.size() == 0)
            begin
                $error("new_cwnd: unexpected result, actual %0d", got);
                errors++;
                return;
            end
            want = pending_cwnd.pop_front();
            if (got !== want)
            begin
                $error("new_cwnd: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [23:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    cwnd_scoreboard sb;
    bit no_idle;
    int hold_off;
    logic [47:0] clock_ms;

    cubic_congestion_window_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= no_idle || ($urandom_range(99) >= 24);
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic send_request(logic is_loss, logic [31:0] cwnd_in, logic [31:0] acked,
                                logic [19:0] delay, logic [47:0] now);
        while (!no_idle && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= is_loss;
        s_tdata <= {4'd0, now, delay, acked, cwnd_in};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(is_loss, cwnd_in, acked, delay, now);
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        while (sb.pending_cwnd.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (600) @(posedge clk);
    endtask

    task automatic random_request();
        logic [31:0] cw;
        logic [31:0] ack;
        logic [19:0] dly;
        int r;
        r = $urandom_range(99);
        cw = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200000, 1);
        ack = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20000);
        dly = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(300));
        if (r < 3)
            clock_ms = 48'({$urandom, $urandom});
        else if (r < 6)
            clock_ms = clock_ms - $urandom_range(5000);
        else
            clock_ms = clock_ms + $urandom_range(3000);
        send_request($urandom_range(99) < 15, cw, ack, dly, clock_ms);
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        no_idle = 1'b0;
        hold_off = 0;
        clock_ms = 48'd1000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, time zero, reversal, zero window
        send_request(1'b0, 32'd1, 32'd0, 20'd0, 48'd0);
        send_request(1'b0, 32'd10000, 32'd2920, 20'd50, 48'd0);
        send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 48'hFFFF_FFFF_FFFF);
        send_request(1'b1, 32'd100000, 32'd0, 20'd0, 48'd0);
        send_request(1'b0, 32'd50000, 32'hFFFF_FFFF, 20'hFFFFF, 48'd5000);
        send_request(1'b0, 32'd60000, 32'd1460, 20'd40, 48'd7000);
        send_request(1'b0, 32'd60000, 32'd1460, 20'd40, 48'd3000);
        send_request(1'b1, 32'd1, 32'd0, 20'd0, 48'd0);
        send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 48'hFFFF_FFFF_FFFF);
        send_request(1'b0, 32'd0, 32'd1000, 20'd1, 48'h8000_0000_0000);
        send_request(1'b1, 32'd0, 32'd0, 20'd0, 48'd0);
        send_request(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 20'h55555, 48'hAAAA_AAAA_AAAA);
        send_request(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 20'hAAAAA, 48'h5555_5555_5555);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_BETA, 24'd65536);
                    write_reg(REG_BETA_MAX, 24'd0);
                    write_reg(REG_ALPHA, 24'hFF_FFFF);
                end
                1:
                begin
                    write_reg(REG_BETA, 24'd0);
                    write_reg(REG_BETA_MAX, 24'd65536);
                    write_reg(REG_ALPHA, 24'd0);
                end
                2:
                begin
                    write_reg(REG_BETA, 24'($urandom_range(65536)));
                    write_reg(REG_BETA_MAX, 24'($urandom_range(65536)));
                    write_reg(REG_ALPHA, 24'($urandom));
                    write_reg(REG_SPARE, 24'($urandom));
                end
                default:
                begin
                    write_reg(REG_BETA, 24'd45875);
                    write_reg(REG_BETA_MAX, 24'd55706);
                    write_reg(REG_ALPHA, 24'd34696);
                end
            endcase
            cfg_we <= 1'b0;
            for (int i = 0; i < 300; i++)
            begin
                no_idle = (ph == 1 && i >= 100 && i < 200);
                if (ph == 2 && i == 50)
                    hold_off = 3000;
                random_request();
            end
            no_idle = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending_cwnd.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/ccw_pkg.sv
rtl/ccw_mul.sv
rtl/ccw_div.sv
rtl/cubic_congestion_window_unit.sv
tb/sv/tb_cubic_congestion_window_unit.sv
